// ===== rtl/casp_pkg.sv =====
package casp_pkg;

  localparam int GAIN_FRAC_BITS         = 8;
  localparam int COUNTS_PER_RADIAN_LOG2 = 12;

  // pi in Q29, rounded to the angle scale
  localparam longint PI_Q29     = 64'd1686629713;
  localparam longint PI_COUNTS  =
    (PI_Q29 + (64'd1 << (28 - COUNTS_PER_RADIAN_LOG2))) >> (29 - COUNTS_PER_RADIAN_LOG2);

  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 48;
  localparam int IN_W    = 18;
  localparam int AERR_W  = 19;
  localparam int ERR_W   = 25;
  localparam int OPB_W   = 26;
  localparam int PROD_W  = GAIN_W + OPB_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RES_W   = 24;
  localparam int CADDR_W = 6;
  localparam int CDATA_W = 64;

  localparam logic [2:0] REG_ANGLE_KP     = 3'd0;
  localparam logic [2:0] REG_ANGLE_KI     = 3'd1;
  localparam logic [2:0] REG_ANGLE_KD     = 3'd2;
  localparam logic [2:0] REG_ANGLE_LIMITS = 3'd3;
  localparam logic [2:0] REG_SPEED_KP     = 3'd4;
  localparam logic [2:0] REG_SPEED_KI     = 3'd5;
  localparam logic [2:0] REG_SPEED_KD     = 3'd6;
  localparam logic [2:0] REG_SPEED_LIMITS = 3'd7;

  localparam logic STAGE_ANGLE = 1'b0;
  localparam logic STAGE_SPEED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AERR,
    ST_SERR,
    ST_MUL_I,
    ST_INT,
    ST_MUL_D,
    ST_SUM,
    ST_OUT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic aerr;
    logic serr;
    logic mul_i;
    logic int_upd;
    logic mul_d;
    logic sum;
    logic fin;
    logic push;
    logic stage;
  } ctl_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] angle_kp;
    logic signed [GAIN_W-1:0] angle_ki;
    logic signed [GAIN_W-1:0] angle_kd;
    logic        [LIM_W-1:0]  angle_limits;
    logic signed [GAIN_W-1:0] speed_kp;
    logic signed [GAIN_W-1:0] speed_ki;
    logic signed [GAIN_W-1:0] speed_kd;
    logic        [LIM_W-1:0]  speed_limits;
  } cfg_t;

  // 24-bit limit field saturated to the largest positive 24-bit value
  function automatic logic [22:0] sat_lim(input logic [23:0] l);
    return l[23] ? 23'h7FFFFF : l[22:0];
  endfunction

  function automatic logic signed [RES_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                        input logic [22:0] lim);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-23){1'b0}}, lim};
    lo = -hi;
    if (v > hi) return hi[RES_W-1:0];
    else if (v < lo) return lo[RES_W-1:0];
    else return v[RES_W-1:0];
  endfunction

endpackage

// ===== rtl/casp_regs.sv =====
module casp_regs
  import casp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CADDR_W-1:0] paddr,
  input  logic [CDATA_W-1:0] pwdata,
  output logic [CDATA_W-1:0] prdata,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[5:3];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ANGLE_KP:     cfg_r.angle_kp     <= pwdata[GAIN_W-1:0];
        REG_ANGLE_KI:     cfg_r.angle_ki     <= pwdata[GAIN_W-1:0];
        REG_ANGLE_KD:     cfg_r.angle_kd     <= pwdata[GAIN_W-1:0];
        REG_ANGLE_LIMITS: cfg_r.angle_limits <= pwdata[LIM_W-1:0];
        REG_SPEED_KP:     cfg_r.speed_kp     <= pwdata[GAIN_W-1:0];
        REG_SPEED_KI:     cfg_r.speed_ki     <= pwdata[GAIN_W-1:0];
        REG_SPEED_KD:     cfg_r.speed_kd     <= pwdata[GAIN_W-1:0];
        REG_SPEED_LIMITS: cfg_r.speed_limits <= pwdata[LIM_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ANGLE_KP:     prdata = {{(CDATA_W-GAIN_W){1'b0}}, cfg_r.angle_kp};
      REG_ANGLE_KI:     prdata = {{(CDATA_W-GAIN_W){1'b0}}, cfg_r.angle_ki};
      REG_ANGLE_KD:     prdata = {{(CDATA_W-GAIN_W){1'b0}}, cfg_r.angle_kd};
      REG_ANGLE_LIMITS: prdata = {{(CDATA_W-LIM_W){1'b0}}, cfg_r.angle_limits};
      REG_SPEED_KP:     prdata = {{(CDATA_W-GAIN_W){1'b0}}, cfg_r.speed_kp};
      REG_SPEED_KI:     prdata = {{(CDATA_W-GAIN_W){1'b0}}, cfg_r.speed_ki};
      REG_SPEED_KD:     prdata = {{(CDATA_W-GAIN_W){1'b0}}, cfg_r.speed_kd};
      REG_SPEED_LIMITS: prdata = {{(CDATA_W-LIM_W){1'b0}}, cfg_r.speed_limits};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/casp_seq.sv =====
module casp_seq
  import casp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_opcode,
  input  logic out_free,
  output logic in_ready,
  output ctl_t ctl
);

  state_t state_r, state_nxt;
  logic   stage_r, stage_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stage_r <= STAGE_SPEED;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_opcode ? ST_AERR : ST_SERR;
          stage_nxt = in_opcode ? STAGE_ANGLE : STAGE_SPEED;
        end
      end
      ST_AERR:  state_nxt = ST_MUL_I;
      ST_SERR:  state_nxt = ST_MUL_I;
      ST_MUL_I: state_nxt = ST_INT;
      ST_INT:   state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (stage_r == STAGE_ANGLE) begin
          state_nxt = ST_SERR;
          stage_nxt = STAGE_SPEED;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // strobes; nothing is taken while reset is held
  always_comb begin
    ctl       = '0;
    ctl.stage = stage_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        ctl.load = in_valid & rst_n;
      end
      ST_AERR:  ctl.aerr    = 1'b1;
      ST_SERR:  ctl.serr    = 1'b1;
      ST_MUL_I: ctl.mul_i   = 1'b1;
      ST_INT:   ctl.int_upd = 1'b1;
      ST_MUL_D: ctl.mul_d   = 1'b1;
      ST_SUM:   ctl.sum     = 1'b1;
      ST_OUT:   ctl.fin     = 1'b1;
      ST_PUSH:  ctl.push    = out_free;
      default:  ctl         = '0;
    endcase
  end

endmodule

// ===== rtl/casp_dp.sv =====
module casp_dp
  import casp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_t                    ctl,
  input  cfg_t                    cfg,
  input  logic                    in_opcode,
  input  logic signed [IN_W-1:0]  in_setpoint,
  input  logic signed [IN_W-1:0]  in_angle,
  input  logic signed [IN_W-1:0]  in_rate,
  input  logic                    in_wrap,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_free,
  output logic signed [RES_W-1:0] out_drive,
  output logic signed [RES_W-1:0] out_target
);

  localparam logic signed [19:0] PI_C     = 20'(PI_COUNTS);
  localparam logic signed [19:0] TWO_PI_C = 20'(2 * PI_COUNTS);

  logic                     op_r, wrap_r;
  logic signed [IN_W-1:0]   sp_r, ang_r, rate_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [OPB_W-1:0]  diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RES_W-1:0]  target_r, drive_r;
  logic signed [AERR_W-1:0] angle_last_r;
  logic signed [RES_W-1:0]  angle_integ_r;
  logic signed [ERR_W-1:0]  speed_last_r;
  logic signed [RES_W-1:0]  speed_integ_r;
  logic                     out_valid_r;
  logic signed [RES_W-1:0]  out_drive_r, out_target_r;

  logic signed [19:0]       ae_raw, ae_wrap;
  logic signed [RES_W-1:0]  rate_tgt;
  logic signed [ERR_W-1:0]  serr;
  logic signed [GAIN_W-1:0] coef;
  logic signed [OPB_W-1:0]  opb, last_ext, diff;
  logic signed [PROD_W-1:0] prod_nxt, prod_sh;
  logic signed [RES_W-1:0]  integ_cur, integ_nxt, res;
  logic signed [ACC_W-1:0]  acc_sh;
  logic [LIM_W-1:0]         limits;
  logic [22:0]              ilim, olim;

  function automatic logic signed [19:0] in_ext20(input logic signed [IN_W-1:0] v);
    return {{(20-IN_W){v[IN_W-1]}}, v};
  endfunction

  // angle error with a single wrap correction
  assign ae_raw  = 20'(in_ext20(sp_r) - in_ext20(ang_r));
  assign ae_wrap = !wrap_r        ? ae_raw :
                   (ae_raw > PI_C)  ? 20'(ae_raw - TWO_PI_C) :
                   (ae_raw < -PI_C) ? 20'(ae_raw + TWO_PI_C) : ae_raw;

  assign rate_tgt = op_r ? target_r : {{(RES_W-IN_W){sp_r[IN_W-1]}}, sp_r};
  assign serr     = {rate_tgt[RES_W-1], rate_tgt} - {{(ERR_W-IN_W){rate_r[IN_W-1]}}, rate_r};

  // stage-selected operands
  assign limits    = (ctl.stage == STAGE_SPEED) ? cfg.speed_limits : cfg.angle_limits;
  assign ilim      = sat_lim(limits[47:24]);
  assign olim      = sat_lim(limits[23:0]);
  assign integ_cur = (ctl.stage == STAGE_SPEED) ? speed_integ_r : angle_integ_r;
  assign last_ext  = (ctl.stage == STAGE_SPEED) ? {speed_last_r[ERR_W-1], speed_last_r}
                   : {{(OPB_W-AERR_W){angle_last_r[AERR_W-1]}}, angle_last_r};
  assign diff      = {err_r[ERR_W-1], err_r} - last_ext;

  always_comb begin
    if (ctl.stage == STAGE_SPEED) begin
      coef = ctl.mul_i ? cfg.speed_ki : ctl.int_upd ? cfg.speed_kp : cfg.speed_kd;
    end else begin
      coef = ctl.mul_i ? cfg.angle_ki : ctl.int_upd ? cfg.angle_kp : cfg.angle_kd;
    end
  end

  // the one shared multiplier
  assign opb      = ctl.mul_d ? diff_r : {err_r[ERR_W-1], err_r};
  assign prod_nxt = coef * opb;

  assign prod_sh   = prod_r >>> GAIN_FRAC_BITS;
  assign integ_nxt = clamp_sym({{(ACC_W-RES_W){integ_cur[RES_W-1]}}, integ_cur}
                               + {{(ACC_W-PROD_W){prod_sh[PROD_W-1]}}, prod_sh}, ilim);
  assign acc_sh    = acc_r >>> GAIN_FRAC_BITS;
  assign res       = clamp_sym(acc_sh + {{(ACC_W-RES_W){integ_cur[RES_W-1]}}, integ_cur}, olim);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r   <= in_opcode;
      wrap_r <= in_wrap;
      sp_r   <= in_setpoint;
      ang_r  <= in_angle;
      rate_r <= in_rate;
    end
    if (ctl.load) target_r <= '0;
    else if (ctl.fin && ctl.stage == STAGE_ANGLE) target_r <= res;
    if (ctl.fin && ctl.stage == STAGE_SPEED) drive_r <= res;
    if (ctl.aerr) err_r <= {{(ERR_W-20){ae_wrap[19]}}, ae_wrap};
    else if (ctl.serr) err_r <= serr;
    if (ctl.mul_i) diff_r <= diff;
    if (ctl.mul_i || ctl.int_upd || ctl.mul_d) prod_r <= prod_nxt;
    if (ctl.mul_d) acc_r <= {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    else if (ctl.sum) acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (ctl.push) begin
      out_drive_r  <= drive_r;
      out_target_r <= target_r;
    end
  end

  // controller state and output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_last_r  <= '0;
      angle_integ_r <= '0;
      speed_last_r  <= '0;
      speed_integ_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (ctl.int_upd && ctl.stage == STAGE_ANGLE) angle_integ_r <= integ_nxt;
      if (ctl.int_upd && ctl.stage == STAGE_SPEED) speed_integ_r <= integ_nxt;
      if (ctl.fin && ctl.stage == STAGE_ANGLE) angle_last_r <= err_r[AERR_W-1:0];
      if (ctl.fin && ctl.stage == STAGE_SPEED) speed_last_r <= err_r;
      if (ctl.push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_drive  = out_drive_r;
  assign out_target = out_target_r;

endmodule

// ===== rtl/cascaded_angle_speed_pid_top.sv =====
// Channel  Dir  Payload (lsb first)                                  Handshake
// in_      in   tdata: setpoint, measured_angle, measured_rate       tvalid/tready
//               tuser: opcode, wrap_enable
// out_     out  tdata: drive, target_rate                            tvalid/tready
// cfg_     in   APB, 8 regs of 64 bits at 8*i, pready tied high      psel/penable
//
// Sequence: one request at a time through a single 16x26 multiplier and
// 44-bit adders and clamps. Speed-only request: error, 5 stage steps and push
// from accept to result register, then the next request is taken in idle;
// cascaded: the angle stage adds error plus 5 steps first. Reset is
// synchronous, active low, and clears gains, limits, integrals and last errors.
// A result waiting on out_tready does not block the next request; a second
// finished result holds in the push step until the output register frees.
module cascaded_angle_speed_pid_top
  import casp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [55:0]        in_tdata,   // [17:0] setpoint, [35:18] measured_angle,
                                         // [53:36] measured_rate, [55:54] zero
  input  logic [1:0]         in_tuser,   // [0] opcode, [1] wrap_enable
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,  // [23:0] drive, [47:24] target_rate
  // register port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CADDR_W-1:0] cfg_paddr,
  input  logic [CDATA_W-1:0] cfg_pwdata,
  output logic [CDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  cfg_t                    cfg;
  ctl_t                    ctl;
  logic                    out_free;
  logic signed [RES_W-1:0] drive, target_rate;

  assign cfg_pready = 1'b1;

  casp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // step sequencer: error, I product, integral update, P/D products, sum, clamp
  casp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser[0]),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .ctl       (ctl)
  );

  casp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .cfg         (cfg),
    .in_opcode   (in_tuser[0]),
    .in_setpoint (in_tdata[17:0]),
    .in_angle    (in_tdata[35:18]),
    .in_rate     (in_tdata[53:36]),
    .in_wrap     (in_tuser[1]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_free    (out_free),
    .out_drive   (drive),
    .out_target  (target_rate)
  );

  assign out_tdata = {target_rate, drive};

  // ready drops once a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a request while still busy");

  // at most one sequencer step active in any cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.load, ctl.aerr, ctl.serr, ctl.mul_i, ctl.int_upd,
              ctl.mul_d, ctl.sum, ctl.fin, ctl.push}))
    else $error("more than one sequencer step active");

  // a push always presents a result next cycle
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> out_tvalid)
    else $error("result pushed but not presented");

  // a speed-only request never leaves a nonzero target rate
  a_speed_only_target: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser[0]) |=> ctl.push [->1] ##1 (target_rate == '0))
    else $error("target rate nonzero for speed-only request");

endmodule

// ===== test/tb.sv =====
module tb;
  import casp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest legitimate quiet spell is the forced output hold-off;
  // anything well past that means the block is wedged.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 172;

  // Packed the same way as out_tdata: drive low, target_rate high.
  typedef struct packed {
    logic [RES_W-1:0] target_rate;
    logic [RES_W-1:0] drive;
  } pid_out_t;

  // Shadow of the register file plus both stage states; predicts drive and
  // target_rate for each accepted request and checks returned results in order.
  class cascade_pid_checker;
    cfg_t     regs;
    longint   last_err[2];
    longint   integ[2];
    pid_out_t expected_outputs[$];
    int       errors;
    int       checked;
    int       n_cascaded;
    int       n_speed;

    function new();
      regs = '0;
      foreach (last_err[i]) begin
        last_err[i] = 0;
        integ[i] = 0;
      end
      errors = 0;
      checked = 0;
      n_cascaded = 0;
      n_speed = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [CDATA_W-1:0] v);
      case (idx)
        REG_ANGLE_KP:     regs.angle_kp = v[GAIN_W-1:0];
        REG_ANGLE_KI:     regs.angle_ki = v[GAIN_W-1:0];
        REG_ANGLE_KD:     regs.angle_kd = v[GAIN_W-1:0];
        REG_ANGLE_LIMITS: regs.angle_limits = v[LIM_W-1:0];
        REG_SPEED_KP:     regs.speed_kp = v[GAIN_W-1:0];
        REG_SPEED_KI:     regs.speed_ki = v[GAIN_W-1:0];
        REG_SPEED_KD:     regs.speed_kd = v[GAIN_W-1:0];
        REG_SPEED_LIMITS: regs.speed_limits = v[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // limit fields above the largest positive 24-bit value saturate
    function longint sat_limit(logic [23:0] f);
      return (f > 24'd8388607) ? 64'sd8388607 : longint'(f);
    endfunction

    function longint clamp_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // one PID step; >>> on a signed longint rounds toward minus infinity
    function longint pid_update(logic st, longint e, logic signed [GAIN_W-1:0] kp,
                                logic signed [GAIN_W-1:0] ki,
                                logic signed [GAIN_W-1:0] kd, logic [LIM_W-1:0] lims);
      longint ilim;
      longint olim;
      longint pd;
      ilim = sat_limit(lims[47:24]);
      olim = sat_limit(lims[23:0]);
      integ[st] = clamp_to(integ[st] + ((longint'(ki) * e) >>> GAIN_FRAC_BITS), ilim);
      pd = (longint'(kp) * e + longint'(kd) * (e - last_err[st])) >>> GAIN_FRAC_BITS;
      last_err[st] = e;
      return clamp_to(pd + integ[st], olim);
    endfunction

    function void note_request(bit cascade, logic signed [IN_W-1:0] sp,
                               logic signed [IN_W-1:0] ang,
                               logic signed [IN_W-1:0] rate, bit wrap);
      longint   e;
      longint   target;
      longint   rate_goal;
      longint   drv;
      pid_out_t o;
      target = 0;
      if (cascade) begin
        e = longint'(sp) - longint'(ang);
        // a single wrap correction, never repeated
        if (wrap) begin
          if (e > PI_COUNTS) e -= 2 * PI_COUNTS;
          else if (e < -PI_COUNTS) e += 2 * PI_COUNTS;
        end
        target = pid_update(STAGE_ANGLE, e, regs.angle_kp, regs.angle_ki, regs.angle_kd,
                            regs.angle_limits);
        rate_goal = target;
        n_cascaded++;
      end else begin
        rate_goal = longint'(sp);
        n_speed++;
      end
      drv = pid_update(STAGE_SPEED, rate_goal - longint'(rate), regs.speed_kp,
                       regs.speed_ki, regs.speed_kd, regs.speed_limits);
      o.drive = drv[RES_W-1:0];
      o.target_rate = target[RES_W-1:0];
      expected_outputs.push_back(o);
    endfunction

    function void check_result(logic [2*RES_W-1:0] data);
      pid_out_t got;
      pid_out_t want;
      got = data;
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected result drive=%0d target_rate=%0d", $time,
                 $signed(got.drive), $signed(got.target_rate));
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      checked++;
      if (got.drive !== want.drive) begin
        $display("%0t: drive mismatch, expected %0d actual %0d", $time,
                 $signed(want.drive), $signed(got.drive));
        errors++;
      end
      if (got.target_rate !== want.target_rate) begin
        $display("%0t: target_rate mismatch, expected %0d actual %0d", $time,
                 $signed(want.target_rate), $signed(got.target_rate));
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [55:0]        in_tdata;   // [17:0] setpoint, [35:18] measured_angle,
                                  // [53:36] measured_rate, [55:54] zero
  logic [1:0]         in_tuser;   // [0] opcode, [1] wrap_enable
  logic               out_tvalid;
  logic               out_tready;
  logic [47:0]        out_tdata;  // [23:0] drive, [47:24] target_rate
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CADDR_W-1:0] cfg_paddr;
  logic [CDATA_W-1:0] cfg_pwdata;
  logic [CDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  cascade_pid_checker sb = new();

  // traffic shaping knobs, percent of cycles
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_active = 1'b0;
  int   idle_cycles = 0;
  int   n_settings = 0;

  cascaded_angle_speed_pid_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Result side: check on the pre-edge handshake, then pick next cycle's ready.
  // A long hold-off, when active, overrides the random stalls.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_active) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: quiet cycles on every port in a row.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function int rand18();
    return int'($urandom_range(262143)) - 131072;
  endfunction

  function int clip18(int v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // mostly modest Q8.8 gains, sometimes the extremes
  function logic [GAIN_W-1:0] pick_gain();
    int r;
    int g;
    r = $urandom_range(7);
    if (r == 0) g = -32768;
    else if (r == 1) g = 32767;
    else g = int'($urandom_range(1024)) - 512;
    return g[GAIN_W-1:0];
  endfunction

  function logic [23:0] pick_limit();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 24'd0;
    if (r == 1) return 24'hFFFFFF;
    if (r == 2) return 24'($urandom());
    return 24'($urandom_range(1 << 20));
  endfunction

  // APB write: setup, access, then one quiet cycle so psel never toggles
  // twice in one step between back-to-back writes.
  task automatic cfg_write(logic [2:0] idx, logic [CDATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_random_config();
    cfg_write(REG_ANGLE_KP, {48'd0, pick_gain()});
    cfg_write(REG_ANGLE_KI, {48'd0, pick_gain()});
    cfg_write(REG_ANGLE_KD, {48'd0, pick_gain()});
    cfg_write(REG_ANGLE_LIMITS, {16'd0, pick_limit(), pick_limit()});
    cfg_write(REG_SPEED_KP, {48'd0, pick_gain()});
    cfg_write(REG_SPEED_KI, {48'd0, pick_gain()});
    cfg_write(REG_SPEED_KD, {48'd0, pick_gain()});
    cfg_write(REG_SPEED_LIMITS, {16'd0, pick_limit(), pick_limit()});
    n_settings++;
  endtask

  // Drop valid and wait out every outstanding result. Always waits on the clock
  // before checking, so a following send never re-raises valid in the same step.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Offer one request, after a random sender gap. Valid stays up on return so
  // back-to-back requests stream without a bubble.
  task automatic send_req(bit cascade, int sp, int ang, int rate, bit wrap);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, rate[17:0], ang[17:0], sp[17:0]};
    in_tuser  <= {wrap, cascade};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cascade, sp[17:0], ang[17:0], rate[17:0], wrap);
  endtask

  initial begin
    int cur_sp;
    int cur_ang;
    int cur_rate;
    bit op;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all limits zero, so every output is forced to zero.
    send_req(1'b1, 5000, -3000, 100, 1'b1);
    send_req(1'b0, -131072, 0, 131071, 1'b0);
    drain();

    // Extreme gains; oversized limits that must saturate to the 24-bit max.
    cfg_write(REG_ANGLE_KP, 64'd256);
    cfg_write(REG_ANGLE_KI, 64'd32767);
    cfg_write(REG_ANGLE_KD, 64'h8000);
    cfg_write(REG_ANGLE_LIMITS, {16'd0, 24'hFFFFFF, 24'h7FFFFF});
    cfg_write(REG_SPEED_KP, 64'h8000);
    cfg_write(REG_SPEED_KI, 64'd256);
    cfg_write(REG_SPEED_KD, 64'd32767);
    cfg_write(REG_SPEED_LIMITS, {16'd0, 24'd1000, 24'h800000});
    n_settings += 2;

    // full-range errors, where one wrap correction is not enough
    send_req(1'b1, 131071, -131072, 0, 1'b1);
    send_req(1'b1, -131072, 131071, -131072, 1'b1);
    // right at and just past plus and minus pi
    send_req(1'b1, int'(PI_COUNTS), 0, 131071, 1'b1);
    send_req(1'b1, int'(PI_COUNTS) + 1, 0, 0, 1'b1);
    send_req(1'b1, -int'(PI_COUNTS), 0, 0, 1'b1);
    send_req(1'b1, 0, int'(PI_COUNTS) + 1, -5, 1'b1);
    send_req(1'b1, 40000, 0, 77, 1'b1);
    // same large errors without wrapping
    send_req(1'b1, 131071, -131072, 0, 1'b0);
    send_req(1'b1, -131072, 131071, 131071, 1'b0);
    // speed stage alone; angle state must stay put
    send_req(1'b0, 131071, 0, -131072, 1'b0);
    send_req(1'b0, -131072, 131071, 131071, 1'b1);
    send_req(1'b0, 0, -131072, 0, 1'b0);
    drain();

    // angle limits zero: target_rate forced to zero while speed still runs
    cfg_write(REG_ANGLE_LIMITS, 64'd0);
    cfg_write(REG_SPEED_LIMITS, {16'd0, 24'd500, 24'd2000});
    n_settings++;
    send_req(1'b1, 20000, -100, 300, 1'b1);
    send_req(1'b1, -20000, 100, -300, 1'b0);
    send_req(1'b1, 7, 7, 7, 1'b1);

    // Random part: each phase has fresh settings and its own idle/stall mix.
    // Most requests follow slowly moving plants so integrals and derivatives
    // build up; the rest are full-range noise.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      program_random_config();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      cur_sp = rand18();
      cur_ang = rand18();
      cur_rate = rand18();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // receiver holds off while the sender keeps pushing: input backs up
        if (ph == 4 && k == 40) begin
          fork
            begin
              hold_active <= 1'b1;
              repeat (300) @(posedge clk);
              hold_active <= 1'b0;
            end
          join_none
        end
        // sender pause until the pipe is empty
        if (ph == 1 && k == ITEMS_PER_PHASE / 2) drain();
        if ($urandom_range(9) < 7) begin
          op = ($urandom_range(9) < 7);
          if ($urandom_range(9) == 0)
            cur_sp = clip18(cur_ang + int'($urandom_range(40000)) - 20000);
          cur_ang = clip18(cur_ang + int'($urandom_range(400)) - 200);
          cur_rate = clip18(cur_rate + int'($urandom_range(1000)) - 500);
          send_req(op, cur_sp, cur_ang, cur_rate, 1'($urandom_range(1)));
        end else begin
          send_req(1'($urandom_range(1)), rand18(), rand18(), rand18(),
                   1'($urandom_range(1)));
        end
      end
    end

    // Flush: everything back, then some slack to catch stray results.
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d cascaded and %0d speed-only requests over %0d register settings,",
             sb.n_cascaded, sb.n_speed, n_settings);
    $display("with idle/stall mixes and a long output hold-off; %0d results, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/casp_pkg.sv
rtl/casp_regs.sv
rtl/casp_seq.sv
rtl/casp_dp.sv
rtl/cascaded_angle_speed_pid_top.sv
test/tb.sv
